### rtl/core/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg: shared types and codes for the order book matcher.
// Holds the transaction structs, the queue entry and the slot record.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int DEFAULT_MAX_ORDERS = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_LIMIT  = 2'd0;
  localparam logic [1:0] KIND_MARKET = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] cancel_id;
  } in_item_t;

  typedef struct packed {
    logic        is_fill;
    logic [31:0] resting_id;
    logic [31:0] incoming_id;
    logic [31:0] fill_price;
    logic [31:0] trade_qty;
    logic [31:0] rested_qty;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        side;
    logic [31:0] limit;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] cancel_id;
    logic [31:0] tid;
  } q_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } slot_t;

endpackage

### rtl/core/obm_ram.sv
// ----------------------------------------------------------------------------
// obm_ram: generic single-port-write, single-port-read RAM.
// The read data is registered.
// ----------------------------------------------------------------------------
module obm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/obm_fifo.sv
// ----------------------------------------------------------------------------
// obm_fifo: short queue between the front and the back of the matcher.
// Lets each side stall without holding up the other.
// ----------------------------------------------------------------------------
module obm_fifo import obm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    nonempty,
  output q_item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [CW-1:0]   cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/obm_front.sv
// ----------------------------------------------------------------------------
// obm_front: accepts input transactions and classifies them.
// Assigns taker ids and resolves the effective price limit.
// ----------------------------------------------------------------------------
module obm_front import obm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output q_item_t  q_item
);

  logic [31:0] next_id_r;
  logic        takes_id;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign takes_id = (in_data.kind == KIND_LIMIT) || (in_data.kind == KIND_MARKET);

  always_comb begin
    q_item.kind      = in_data.kind;
    q_item.side      = in_data.side;
    q_item.price     = in_data.price;
    q_item.qty       = in_data.quantity;
    q_item.cancel_id = in_data.cancel_id;
    q_item.tid       = next_id_r;
    q_item.limit     = (in_data.kind == KIND_MARKET) ? 32'd0 : in_data.price;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= 32'd1;
    end else if (q_push && takes_id) begin
      next_id_r <= next_id_r + 32'd1;
    end
  end

endmodule

### rtl/core/obm_back.sv
// ----------------------------------------------------------------------------
// obm_back: carries out orders and cancels against the resting book.
// Scans the slot RAM for the best maker, emits fills and the completion.
// ----------------------------------------------------------------------------
module obm_back import obm_pkg::*; #(
  parameter int MAX_ORDERS = DEFAULT_MAX_ORDERS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  q_item_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(MAX_ORDERS);
  localparam int SW = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SDONE,
    S_DECIDE,
    S_REST
  } state_t;

  state_t                  state_r;
  q_item_t                 cur_r;
  logic [31:0]             qty_r;
  logic [MAX_ORDERS-1:0]   valid_r;
  logic [IW-1:0]           cnt_r;
  logic                    pv_r;
  logic [IW-1:0]           pidx_r;
  logic                    best_f_r;
  logic [IW-1:0]           best_idx_r;
  slot_t                   best_r;
  logic                    free_f_r;
  logic [IW-1:0]           free_idx_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  slot_t                   rdata;
  logic [SW-1:0]           rdata_raw;
  logic                    we;
  logic [IW-1:0]           waddr;
  slot_t                   wdata;

  logic                    can_emit;
  logic                    is_cancel;
  logic                    opp;
  logic                    cand_ok;
  logic                    better;
  logic                    take_best;
  logic                    take_free;
  logic                    hit;
  logic [31:0]             fill;
  logic [31:0]             maker_rem;
  logic [31:0]             qty_nxt;
  logic                    do_rest;
  logic                    needs_scan;
  out_item_t               done_item;
  out_item_t               cancel_item;
  out_item_t               fill_item;
  out_item_t               emit_item;
  logic                    emit;

  obm_ram #(.WIDTH(SW), .DEPTH(MAX_ORDERS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_r),
    .rdata (rdata_raw)
  );

  assign rdata     = slot_t'(rdata_raw);
  assign can_emit  = !out_valid_r || !out_stall;
  assign is_cancel = (cur_r.kind == KIND_CANCEL);
  assign opp       = ~cur_r.side;
  assign cand_ok   = pv_r && valid_r[pidx_r];
  assign needs_scan = (q_head.kind == KIND_CANCEL) ||
                      (((q_head.kind == KIND_LIMIT) || (q_head.kind == KIND_MARKET)) &&
                       (q_head.qty != 32'd0));

  always_comb begin
    if (opp == SIDE_SELL) begin
      better = rdata.price < best_r.price;
    end else begin
      better = rdata.price > best_r.price;
    end
    if (rdata.price == best_r.price && rdata.id < best_r.id) begin
      better = 1'b1;
    end
    if (is_cancel) begin
      take_best = cand_ok && !best_f_r && (rdata.id == cur_r.cancel_id);
    end else begin
      take_best = cand_ok && (rdata.side == opp) && (!best_f_r || better);
    end
    take_free = pv_r && !valid_r[pidx_r] && !free_f_r;
  end

  always_comb begin
    hit = best_f_r;
    if (cur_r.limit != 32'd0) begin
      if (cur_r.side == SIDE_BUY && best_r.price > cur_r.limit) begin
        hit = 1'b0;
      end
      if (cur_r.side == SIDE_SELL && best_r.price < cur_r.limit) begin
        hit = 1'b0;
      end
    end
    fill      = (qty_r < best_r.qty) ? qty_r : best_r.qty;
    maker_rem = best_r.qty - fill;
    qty_nxt   = qty_r - fill;
    do_rest   = (cur_r.kind == KIND_LIMIT) && (qty_r != 32'd0);
  end

  always_comb begin
    we    = 1'b0;
    waddr = best_idx_r;
    wdata = best_r;
    wdata.qty = maker_rem;
    if (state_r == S_DECIDE && !is_cancel && hit && can_emit) begin
      we = 1'b1;
    end else if (state_r == S_REST && do_rest && free_f_r && can_emit) begin
      we          = 1'b1;
      waddr       = free_idx_r;
      wdata.id    = cur_r.tid;
      wdata.side  = cur_r.side;
      wdata.price = cur_r.price;
      wdata.qty   = qty_r;
    end
  end

  always_comb begin
    done_item      = '0;
    done_item.last = 1'b1;
    if (cur_r.kind == KIND_LIMIT || cur_r.kind == KIND_MARKET) begin
      done_item.incoming_id = cur_r.tid;
      if (do_rest) begin
        if (free_f_r) begin
          done_item.rested_qty = qty_r;
        end else begin
          done_item.status = STATUS_FULL;
        end
      end
    end
    cancel_item             = '0;
    cancel_item.last        = 1'b1;
    cancel_item.incoming_id = cur_r.cancel_id;
    if (!best_f_r) begin
      cancel_item.status = STATUS_NOT_FOUND;
    end
    fill_item             = '0;
    fill_item.is_fill     = 1'b1;
    fill_item.resting_id  = best_r.id;
    fill_item.incoming_id = cur_r.tid;
    fill_item.fill_price  = best_r.price;
    fill_item.trade_qty   = fill;
  end

  always_comb begin
    emit      = 1'b0;
    emit_item = done_item;
    case (state_r)
      S_DECIDE: begin
        if (is_cancel) begin
          emit      = 1'b1;
          emit_item = cancel_item;
        end else if (hit) begin
          emit      = 1'b1;
          emit_item = fill_item;
        end
      end
      S_REST: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pv_r        <= 1'b0;
      cnt_r       <= '0;
      best_f_r    <= 1'b0;
      free_f_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid_r <= emit;
        if (emit) begin
          out_r <= emit_item;
        end
      end
      if (take_best) begin
        best_f_r   <= 1'b1;
        best_idx_r <= pidx_r;
        best_r     <= rdata;
      end
      if (take_free) begin
        free_f_r   <= 1'b1;
        free_idx_r <= pidx_r;
      end
      pv_r   <= (state_r == S_SCAN);
      pidx_r <= cnt_r;
      case (state_r)
        S_IDLE: begin
          if (q_nonempty) begin
            cur_r    <= q_head;
            qty_r    <= q_head.qty;
            cnt_r    <= '0;
            best_f_r <= 1'b0;
            free_f_r <= 1'b0;
            if (needs_scan) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_REST;
            end
          end
        end
        S_SCAN: begin
          if (cnt_r == IW'(MAX_ORDERS - 1)) begin
            state_r <= S_SDONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SDONE: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (is_cancel) begin
            if (can_emit) begin
              if (best_f_r) begin
                valid_r[best_idx_r] <= 1'b0;
              end
              state_r <= S_IDLE;
            end
          end else if (!hit) begin
            state_r <= S_REST;
          end else if (can_emit) begin
            if (maker_rem == 32'd0) begin
              valid_r[best_idx_r] <= 1'b0;
            end
            qty_r    <= qty_nxt;
            cnt_r    <= '0;
            best_f_r <= 1'b0;
            free_f_r <= 1'b0;
            if (qty_nxt != 32'd0) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_REST;
            end
          end
        end
        S_REST: begin
          if (can_emit) begin
            if (do_rest && free_f_r) begin
              valid_r[free_idx_r] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/order_book_matcher.sv
// ----------------------------------------------------------------------------
// order_book_matcher: price-time priority limit order book.
// Each transaction is a limit order, a market order or a cancel. It passes
// the queue into the back, which then scans the slot RAM (one slot read per
// cycle on its single read port): a cancel takes one scan, an order takes one
// scan per fill plus one final scan when it stops before its quantity runs
// out, and then emits its completion. A zero-quantity order or an unused-kind
// transaction needs no scan. A stall on the result channel holds the back
// until it can emit again.
// ----------------------------------------------------------------------------
module order_book_matcher import obm_pkg::*; #(
  parameter int MAX_ORDERS = DEFAULT_MAX_ORDERS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic    q_full;
  logic    q_push;
  q_item_t q_in;
  logic    q_pop;
  logic    q_nonempty;
  q_item_t q_head;

  obm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  obm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  obm_back #(.MAX_ORDERS(MAX_ORDERS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### tb/order_book_matcher_tb.sv
// ----------------------------------------------------------------------------
// order_book_matcher_tb: self-checking testbench for the order book matcher.
// A queue-fed driver offers limit, market and cancel transactions, a monitor
// compares every result with a price-time priority book kept in the bench.
// ----------------------------------------------------------------------------
module order_book_matcher_tb;
  import obm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = DEFAULT_MAX_ORDERS;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  always #1 clk = ~clk;

  order_book_matcher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  slot_t book [SLOTS];
  logic book_used [SLOTS];
  logic [31:0] next_order_id = 32'd1;
  logic [31:0] recent_ids [$];

  in_item_t pending_orders [$];
  out_item_t expected_reports [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit start_hold = 1'b0;
  bit hold_used = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  logic holding;

  assign holding = (hold_left != 0) || (start_hold && !hold_used);

  function automatic void add_order(in_item_t t);
    pending_orders.insert(pending_orders.size(), t);
  endfunction

  function automatic void add_expected(out_item_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic int best_resting(logic s);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (book_used[i] && book[i].side == s) begin
        if (b < 0) begin
          b = i;
        end else if ((s == SIDE_SELL ? book[i].price < book[b].price
                                     : book[i].price > book[b].price) ||
                     (book[i].price == book[b].price && book[i].id < book[b].id)) begin
          b = i;
        end
      end
    end
    return b;
  endfunction

  task automatic match_order(input in_item_t t);
    out_item_t r;
    logic [31:0] tid, lim, q, f;
    int b, fr;
    r = '0;
    r.last = 1'b1;
    if (t.kind == KIND_CANCEL) begin
      r.incoming_id = t.cancel_id;
      r.status = STATUS_NOT_FOUND;
      for (int i = 0; i < SLOTS; i++) begin
        if (book_used[i] && book[i].id == t.cancel_id) begin
          book_used[i] = 1'b0;
          r.status = STATUS_OK;
          break;
        end
      end
      add_expected(r);
      return;
    end
    if (t.kind == KIND_UNUSED) begin
      add_expected(r);
      return;
    end
    tid = next_order_id;
    next_order_id = next_order_id + 32'd1;
    recent_ids.insert(recent_ids.size(), tid);
    if (recent_ids.size() > 48) recent_ids.delete(0);
    lim = (t.kind == KIND_MARKET) ? 32'd0 : t.price;
    q = t.quantity;
    while (q != 0) begin
      out_item_t fl;
      b = best_resting(~t.side);
      if (b < 0) break;
      if (lim != 0 && t.side == SIDE_BUY && book[b].price > lim) break;
      if (lim != 0 && t.side == SIDE_SELL && book[b].price < lim) break;
      f = (q < book[b].qty) ? q : book[b].qty;
      fl = '0;
      fl.is_fill = 1'b1;
      fl.resting_id = book[b].id;
      fl.incoming_id = tid;
      fl.fill_price = book[b].price;
      fl.trade_qty = f;
      add_expected(fl);
      book[b].qty = book[b].qty - f;
      q = q - f;
      if (book[b].qty == 0) book_used[b] = 1'b0;
    end
    r.incoming_id = tid;
    if (t.kind == KIND_LIMIT && q != 0) begin
      fr = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!book_used[i]) begin
          fr = i;
          break;
        end
      end
      if (fr < 0) begin
        r.status = STATUS_FULL;
      end else begin
        book_used[fr] = 1'b1;
        book[fr] = '{id: tid, side: t.side, price: t.price, qty: q};
        r.rested_qty = q;
      end
    end
    add_expected(r);
  endtask

  function automatic in_item_t make_order(logic [1:0] k, logic s, logic [31:0] p,
                                          logic [31:0] q, logic [31:0] c);
    in_item_t t;
    t.kind = k;
    t.side = s;
    t.price = p;
    t.quantity = q;
    t.cancel_id = c;
    return t;
  endfunction

  function automatic in_item_t random_order();
    logic [31:0] p, q, c;
    int sel;
    logic s;
    s = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    p = (s == SIDE_BUY) ? 32'd100 - $urandom_range(0, 8) : 32'd96 + $urandom_range(0, 8);
    if ($urandom_range(0, 19) == 0) p = $urandom;
    if ($urandom_range(0, 29) == 0) p = 32'd0;
    q = $urandom_range(1, 40);
    if ($urandom_range(0, 24) == 0) q = $urandom;
    if ($urandom_range(0, 29) == 0) q = 32'd0;
    c = (recent_ids.size() > 0 && $urandom_range(0, 3) != 0) ?
        recent_ids[$urandom_range(0, recent_ids.size() - 1)] : $urandom;
    if (sel < 55) return make_order(KIND_LIMIT, s, p, q, $urandom);
    if (sel < 75) return make_order(KIND_MARKET, s, $urandom, q, $urandom);
    if (sel < 97) return make_order(KIND_CANCEL, s, $urandom, $urandom, c);
    return make_order(KIND_UNUSED, s, $urandom, $urandom, $urandom);
  endfunction

  // Driver: holds the payload while stalled, may pause between transactions.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        match_order(in_data);
        pending_orders.delete(0);
      end
      if (in_valid && in_stall) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && !holding && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_orders.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_orders[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = expected_reports[0];
          expected_reports.delete(0);
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if (start_hold && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
        hold_left <= 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left <= $urandom_range(1, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on accepted transactions in either direction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || holding) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("order_book_matcher_tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) book_used[i] = 1'b0;
    // Directed: resting, priority by price then id, limits, specials.
    add_order(make_order(KIND_LIMIT, SIDE_SELL, 32'd105, 32'd10, 0));
    add_order(make_order(KIND_LIMIT, SIDE_SELL, 32'd103, 32'd5, 0));
    add_order(make_order(KIND_LIMIT, SIDE_SELL, 32'd103, 32'd7, 0));
    add_order(make_order(KIND_LIMIT, SIDE_BUY, 32'd104, 32'd9, 0));
    add_order(make_order(KIND_LIMIT, SIDE_BUY, 32'd0, 32'd4, 0));
    add_order(make_order(KIND_LIMIT, SIDE_BUY, 32'd0, 32'd0, 0));
    add_order(make_order(KIND_MARKET, SIDE_BUY, 32'hFFFFFFFF, 32'd50, 0));
    add_order(make_order(KIND_LIMIT, SIDE_BUY, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'hFFFFFFFF));
    add_order(make_order(KIND_MARKET, SIDE_SELL, 0, 32'd3, 0));
    add_order(make_order(KIND_LIMIT, SIDE_SELL, 32'd1, 32'd2, 0));
    add_order(make_order(KIND_CANCEL, SIDE_SELL, 0, 0, 32'd8));
    add_order(make_order(KIND_CANCEL, SIDE_BUY, 0, 0, 32'd8));
    add_order(make_order(KIND_CANCEL, SIDE_BUY, 0, 0, 32'hFFFFFFFF));
    add_order(make_order(KIND_UNUSED, SIDE_SELL, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'hFFFFFFFF));
    // Fill the book until it reports full.
    for (int i = 0; i < SLOTS + 2; i++)
      add_order(make_order(KIND_LIMIT, SIDE_SELL, 32'd200 + i, 32'd1, 0));
    add_order(make_order(KIND_MARKET, SIDE_BUY, 0, 32'hFFFFFFFF, 0));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_orders.size() > 0) @(posedge clk);
    for (int n = 0; n < 320; n++) begin
      if (n == 60) begin
        start_hold <= 1'b1;
        for (int k = 0; k < 12; k++) add_order(random_order());
      end
      if (n == 280) calm <= 1'b1;
      add_order(random_order());
      while (pending_orders.size() > 2) @(posedge clk);
    end
    while (pending_orders.size() > 0 || in_valid) @(posedge clk);
    while (expected_reports.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("order_book_matcher_tb: done, clean");
    end else begin
      $display("order_book_matcher_tb: done, errors");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/obm_pkg.sv
rtl/core/obm_ram.sv
rtl/core/obm_fifo.sv
rtl/core/obm_front.sv
rtl/core/obm_back.sv
rtl/core/order_book_matcher.sv
tb/order_book_matcher_tb.sv
